// ----- rtl/core/sipd_pkg.sv -----
// Shared types, constants and helpers for the signed integer to padded
// decimal converter. No dependencies; used by the interfaces and the top level.
package sipd_pkg;

  // Fixed field widths of the input and output words
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned MINW_W  = 5;
  localparam int unsigned CHAR_W  = 6;

  // Default parameter values for the top level
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned MAX_WIDTH_DEF  = 16;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 6'd32;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  // Powers of ten for the digit subtract unit
  localparam int unsigned POW_W     = 36;
  localparam int unsigned POW_N     = 10;
  localparam int unsigned POW_IDX_W = 4;
  localparam logic [POW_W-1:0] POW10 [POW_N] = '{
    36'd1, 36'd10, 36'd100, 36'd1000, 36'd10000, 36'd100000,
    36'd1000000, 36'd10000000, 36'd100000000, 36'd1000000000
  };

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  // Number of decimal digits in 2^(bits-1), the largest magnitude
  function automatic int num_digits(input int bits);
    longint unsigned m;
    int n;
    m = 64'd1 << (bits - 1);
    n = 1;
    m = m / 10;
    while (m != 0) begin
      n = n + 1;
      m = m / 10;
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/sipd_stream_if.sv -----
// Valid/ready stream interfaces for the input and output words.
// Depends on sipd_pkg for field widths.
interface sipd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sipd_pkg::VALUE_W-1:0]  value;
  logic        [sipd_pkg::MINW_W-1:0]   min_width;

  modport source (output valid, output value, output min_width, input ready);
  modport sink   (input valid, input value, input min_width, output ready);
endinterface

interface sipd_out_if;
  logic                          valid;
  logic                          ready;
  logic [sipd_pkg::CHAR_W-1:0]   char_code;
  logic                          last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- rtl/core/signed_int_to_padded_decimal.sv -----
// Signed integer to blank-padded decimal text, one character per output word.
// Depends on sipd_pkg and the stream interfaces in sipd_stream_if.sv.
//
//   channel  dir  word fields           meaning
//   in_i     in   value, min_width      number to convert, minimum field width
//   out_o    out  char_code, last       ASCII character, final-character flag
//
// One number is accepted, then each of its D digits (D is the digit count of
// 2^(VALUE_BITS-1)) is found bit by bit, then max(min(min_width, MAX_WIDTH),
// sign + digits) characters are emitted one per cycle. The digit extraction
// runs one compare-subtract against a scaled power of ten per cycle. in_i is
// ready only while the sequencer idles; a stalled out_o holds the emission.
// Reset clears the sequencer and output valid only; no clearing pass.
module signed_int_to_padded_decimal #(
  parameter int unsigned VALUE_BITS = sipd_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_WIDTH  = sipd_pkg::MAX_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sipd_in_if.sink           in_i,
  sipd_out_if.source        out_o
);

  localparam int unsigned NdMax = sipd_pkg::num_digits(VALUE_BITS);
  localparam int unsigned DigW  = $clog2(NdMax);
  localparam int unsigned NdW   = $clog2(NdMax + 1);
  localparam int unsigned LenW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SubW  = VALUE_BITS + 4;

  sipd_pkg::state_e state_q, state_d;

  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic                  neg_q, neg_d;
  logic [LenW-1:0]       width_q, width_d;
  logic [DigW-1:0]       k_q, k_d;
  logic [1:0]            b_q, b_d;
  logic [3:0]            dig_q, dig_d;
  logic [NdW-1:0]        nd_q, nd_d;
  logic                  sig_q, sig_d;
  logic [LenW-1:0]       pos_q, pos_d;
  logic [3:0]            digs_q [NdMax];

  logic                      out_valid_q, out_valid_d;
  logic [sipd_pkg::CHAR_W-1:0] out_char_q, out_char_d;
  logic                      out_last_q, out_last_d;

  // Input decode
  logic [VALUE_BITS-1:0] raw;
  logic                  raw_neg;
  logic [VALUE_BITS-1:0] mag_in;
  logic [LenW-1:0]       width_in;
  logic                  in_fire;

  assign raw      = in_i.value[VALUE_BITS-1:0];
  assign raw_neg  = raw[VALUE_BITS-1];
  assign mag_in   = raw_neg ? ((~raw) + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;
  assign width_in = ({1'b0, in_i.min_width} > 6'(MAX_WIDTH)) ? LenW'(MAX_WIDTH)
                                                              : LenW'(in_i.min_width);
  assign in_i.ready = (state_q == sipd_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Shared compare-subtract unit: rem - 10^k * 2^b
  logic [sipd_pkg::POW_W-1:0] pow_shift;
  logic [SubW-1:0]            trial;
  logic                       ge;
  logic [3:0]                 dig_new;

  assign pow_shift = sipd_pkg::POW10[sipd_pkg::POW_IDX_W'(k_q)] << b_q;
  assign trial     = {4'b0000, rem_q} - pow_shift[SubW-1:0];
  assign ge        = !trial[SubW-1];

  always_comb begin
    dig_new = dig_q;
    dig_new[b_q] = ge;
  end

  // Emission bookkeeping
  logic [LenW-1:0] textlen;
  logic [LenW-1:0] total;
  logic [LenW-1:0] pad;
  logic [LenW-1:0] didx;
  logic            out_free;

  assign textlen  = LenW'(nd_q) + LenW'(neg_q);
  assign total    = (width_q > textlen) ? width_q : textlen;
  assign pad      = total - textlen;
  assign didx     = total - LenW'(1) - pos_q;
  assign out_free = !out_valid_q || out_o.ready;

  // Sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    width_d     = width_q;
    k_d         = k_q;
    b_d         = b_q;
    dig_d       = dig_q;
    nd_d        = nd_q;
    sig_d       = sig_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    case (state_q)
      sipd_pkg::ST_IDLE: begin
        if (in_fire) begin
          rem_d   = mag_in;
          neg_d   = raw_neg;
          width_d = width_in;
          k_d     = DigW'(NdMax - 1);
          b_d     = 2'd3;
          dig_d   = 4'd0;
          nd_d    = NdW'(1);
          sig_d   = 1'b0;
          state_d = sipd_pkg::ST_CONV;
        end
      end
      sipd_pkg::ST_CONV: begin
        // Keep the remainder when the scaled power fits
        if (ge) begin
          rem_d = trial[VALUE_BITS-1:0];
        end
        dig_d = dig_new;
        if (b_q == 2'd0) begin
          // Digit done: note the most significant nonzero digit
          if (dig_new != 4'd0 && !sig_q) begin
            sig_d = 1'b1;
            nd_d  = NdW'(k_q) + NdW'(1);
          end
          dig_d = 4'd0;
          b_d   = 2'd3;
          if (k_q == DigW'(0)) begin
            pos_d   = LenW'(0);
            state_d = sipd_pkg::ST_EMIT;
          end else begin
            k_d = k_q - DigW'(1);
          end
        end else begin
          b_d = b_q - 2'd1;
        end
      end
      sipd_pkg::ST_EMIT: begin
        // Load the next character once the output register frees up
        if (out_free) begin
          out_valid_d = 1'b1;
          if (pos_q < pad) begin
            out_char_d = sipd_pkg::CHAR_BLANK;
          end else if (neg_q && pos_q == pad) begin
            out_char_d = sipd_pkg::CHAR_MINUS;
          end else begin
            out_char_d = sipd_pkg::CHAR_ZERO + {2'b00, digs_q[didx[DigW-1:0]]};
          end
          out_last_d = (pos_q == total - LenW'(1));
          if (pos_q == total - LenW'(1)) begin
            state_d = sipd_pkg::ST_IDLE;
          end else begin
            pos_d = pos_q + LenW'(1);
          end
        end
      end
      default: begin
        state_d = sipd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sipd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    width_q    <= width_d;
    k_q        <= k_d;
    b_q        <= b_d;
    dig_q      <= dig_d;
    nd_q       <= nd_d;
    sig_q      <= sig_d;
    pos_q      <= pos_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // Store each finished digit at its decimal position
  always_ff @(posedge clk_i) begin
    if (state_q == sipd_pkg::ST_CONV && b_q == 2'd0) begin
      digs_q[k_q] <= dig_new;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = out_char_q;
  assign out_o.last      = out_last_q;

  // Checks
  a_nd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sipd_pkg::ST_EMIT) |-> (nd_q >= NdW'(1) && nd_q <= NdW'(NdMax)))
    else $error("digit count out of range during emission");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_char_q == sipd_pkg::CHAR_BLANK ||
                     out_char_q == sipd_pkg::CHAR_MINUS ||
                     (out_char_q >= sipd_pkg::CHAR_ZERO &&
                      out_char_q <= sipd_pkg::CHAR_NINE)))
    else $error("output character outside the blank, minus and digit codes");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=>
      (out_valid_q && $stable(out_char_q) && $stable(out_last_q)))
    else $error("stalled output word changed before it was taken");

  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == sipd_pkg::ST_CONV && k_q == DigW'(NdMax - 1)))
    else $error("accepted word did not start digit extraction");

endmodule
